### rtl/sajc_pkg.sv
// Shared types and constants of the servo axis jog controller.
`timescale 1ns / 1ps
`default_nettype none

package sajc_pkg;

   localparam int AXES_DEFAULT = 4;
   localparam int LIMIT_AXES   = 4;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 12;
   localparam int POS_W        = 12;
   localparam int STEP_W       = 4;

   typedef enum logic [1:0] {
      REQ_BUTTON = 2'd0,
      REQ_STICK  = 2'd1,
      REQ_TICK   = 2'd2,
      REQ_REHOME = 2'd3
   } sajc_req_kind_type;

   localparam logic [3:0] MOTOR_BUTTON = 4'd6;
   localparam logic [3:0] STICK_JOG    = 4'd1;
   localparam logic [3:0] STICK_ANGLE  = 4'd3;
   localparam logic [2:0] MOTOR_REG    = 3'd4;
   localparam logic [2:0] ANGLE_REG    = 3'd5;

   localparam logic [LIMIT_AXES-1:0][POS_W-1:0] MIN_RESET = {12'd100, 12'd100, 12'd100, 12'd150};
   localparam logic [LIMIT_AXES-1:0][POS_W-1:0] MAX_RESET = {12'd550, 12'd475, 12'd380, 12'd500};

   typedef struct packed {
      logic [1:0]         req_type;
      logic [3:0]         control_id;
      logic               pressed;
      logic signed [15:0] stick_value;
   } sajc_req_type;

   typedef struct packed {
      logic [2:0]  reg_index;
      logic [15:0] reg_value;
      logic        last_write;
   } sajc_rsp_type;

   typedef struct packed {
      logic                     commit;
      logic [1:0]               req_type;
      logic [3:0]               control_id;
      logic                     pressed;
      logic signed [STEP_W-1:0] jog_step;
   } sajc_axis_ctrl_type;

   typedef struct packed {
      logic             tick_hit;
      logic [2:0]       tick_index;
      logic [POS_W-1:0] tick_value;
      logic [POS_W-1:0] rehome_value;
   } sajc_axis_status_type;

endpackage

`default_nettype wire

### rtl/servo_axis_jog_controller.sv
// Top level of the servo axis jog controller: input stage, sequencing and result register.
//
// Usage: event transactions enter on req_valid/req_stall with req_data; register
// write transactions leave on rsp_valid/rsp_stall with rsp_data. Limits are written
// on csr_we/csr_index/csr_wdata; the user is to write them only while the block is
// idle, which the block itself does not enforce. A transaction is held in the input
// register and its result passes to the result register, which drives rsp_valid.
// Throughput: one transaction per cycle for button, stick and tick events, each
// giving at most one write, while the receiver does not stall. A rehome holds the
// input stage until it has given one write per axis (four at the default), as the
// result register takes one write a cycle.
// Reset (synchronous, active high) restores the limit defaults, puts every axis at
// its minimum, clears selections, the motor gate and the jog step, and empties both
// stages. When the receiver stalls, the pending result holds in the result register,
// and the input stage holds once its own transaction has a result to deliver.
`timescale 1ns / 1ps
`default_nettype none

module servo_axis_jog_controller #(
   parameter int AXES = sajc_pkg::AXES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sajc_pkg::sajc_req_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sajc_pkg::sajc_rsp_type          rsp_data,
   input  logic                            csr_we,
   input  logic [sajc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sajc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sajc_pkg::*;

   localparam int NAX  = AXES < LIMIT_AXES ? AXES : LIMIT_AXES;
   localparam int IDXW = NAX > 1 ? $clog2(NAX) : 1;

   logic                     in_valid_ff;
   sajc_req_type             in_ff;
   logic [IDXW-1:0]          rh_idx_ff;
   logic                     motor_gate_ff;
   logic signed [STEP_W-1:0] jog_step_ff;
   logic                     out_valid_ff;
   sajc_rsp_type             out_ff;

   logic signed [STEP_W-1:0] stick_step;
   logic [15:0]              motor_speed;
   logic [15:0]              angle;
   sajc_axis_ctrl_type       axis_ctrl;
   sajc_axis_status_type     axis_status;

   logic         has_result;
   sajc_rsp_type result;
   logic         rh_last;
   logic         out_ready;
   logic         emit;
   logic         done;

   sajc_stick u_stick (
      .stick_value (in_ff.stick_value),
      .jog_step    (stick_step),
      .motor_speed (motor_speed),
      .angle       (angle)
   );

   sajc_axes #(
      .AXES (AXES)
   ) u_axes (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .ctrl       (axis_ctrl),
      .rehome_idx (rh_idx_ff),
      .status     (axis_status)
   );

   always_comb begin
      rh_last    = (rh_idx_ff == IDXW'(NAX - 1));
      has_result = 1'b0;
      result     = '0;
      unique case (in_ff.req_type)
         REQ_BUTTON: begin
         end
         REQ_STICK: begin
            if (in_ff.control_id == STICK_JOG) begin
               has_result = motor_gate_ff;
               result     = '{reg_index: MOTOR_REG, reg_value: motor_speed, last_write: 1'b1};
            end else if (in_ff.control_id == STICK_ANGLE) begin
               has_result = 1'b1;
               result     = '{reg_index: ANGLE_REG, reg_value: angle, last_write: 1'b1};
            end
         end
         REQ_TICK: begin
            has_result = axis_status.tick_hit;
            result     = '{reg_index: axis_status.tick_index,
                           reg_value: {4'b0, axis_status.tick_value}, last_write: 1'b1};
         end
         REQ_REHOME: begin
            has_result = 1'b1;
            result     = '{reg_index: 3'(rh_idx_ff),
                           reg_value: {4'b0, axis_status.rehome_value}, last_write: rh_last};
         end
         default: begin
         end
      endcase
      out_ready = !out_valid_ff || !rsp_stall;
      emit      = in_valid_ff && has_result && out_ready;
      done      = in_valid_ff && (has_result ?
                  (out_ready && (in_ff.req_type != REQ_REHOME || rh_last)) : 1'b1);
      req_stall = in_valid_ff && !done;

      axis_ctrl.commit     = done;
      axis_ctrl.req_type   = in_ff.req_type;
      axis_ctrl.control_id = in_ff.control_id;
      axis_ctrl.pressed    = in_ff.pressed;
      axis_ctrl.jog_step   = jog_step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         in_ff         <= '0;
         rh_idx_ff     <= '0;
         motor_gate_ff <= 1'b0;
         jog_step_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
            in_ff       <= req_data;
         end else if (done) begin
            in_valid_ff <= 1'b0;
         end
         if (emit && in_ff.req_type == REQ_REHOME) begin
            rh_idx_ff <= rh_last ? '0 : rh_idx_ff + 1'b1;
         end
         if (done && in_ff.req_type == REQ_BUTTON && in_ff.control_id == MOTOR_BUTTON) begin
            motor_gate_ff <= in_ff.pressed;
         end
         if (done && in_ff.req_type == REQ_STICK && in_ff.control_id == STICK_JOG) begin
            jog_step_ff <= stick_step;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
            out_ff       <= result;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

### rtl/sajc_stick.sv
// Stick deflection scaling: jog step, motor speed and clamped angle.
`timescale 1ns / 1ps
`default_nettype none

module sajc_stick (
   input  logic signed [15:0]                  stick_value,
   output logic signed [sajc_pkg::STEP_W-1:0]  jog_step,
   output logic [15:0]                         motor_speed,
   output logic [15:0]                         angle
);
   import sajc_pkg::*;

   localparam logic [16:0] JOG_MUL   = 17'd107375;
   localparam int          JOG_SHIFT = 29;
   localparam logic [16:0] SPD_MUL   = 17'd119838;
   localparam int          SPD_SHIFT = 22;
   localparam logic [16:0] ANG_MUL   = 17'd83887;
   localparam int          ANG_SHIFT = 23;
   localparam logic [9:0]  ANG_MAX   = 10'd300;

   logic        neg;
   logic [15:0] mag;
   logic [32:0] jog_prod;
   logic [32:0] spd_prod;
   logic [32:0] ang_prod;
   logic [3:0]  jog_q;
   logic [10:0] spd_q;
   logic [9:0]  ang_q;

   always_comb begin
      neg      = stick_value[15];
      mag      = neg ? 16'(-stick_value) : 16'(stick_value);
      jog_prod = {17'b0, mag} * {16'b0, JOG_MUL};
      spd_prod = {17'b0, mag} * {16'b0, SPD_MUL};
      ang_prod = {17'b0, mag} * {16'b0, ANG_MUL};
      jog_q    = jog_prod[JOG_SHIFT+3:JOG_SHIFT];
      spd_q    = spd_prod[SPD_SHIFT+10:SPD_SHIFT];
      ang_q    = ang_prod[ANG_SHIFT+9:ANG_SHIFT];
      jog_step = neg ? -$signed(jog_q) : $signed(jog_q);
      motor_speed = neg ? -{5'b0, spd_q} : {5'b0, spd_q};
      if (neg) begin
         angle = 16'd0;
      end else if (ang_q > ANG_MAX) begin
         angle = {6'b0, ANG_MAX};
      end else begin
         angle = {6'b0, ang_q};
      end
   end

endmodule

`default_nettype wire

### rtl/sajc_axes.sv
// Axis positions, selection flags and limit registers with jog and rehome update.
`timescale 1ns / 1ps
`default_nettype none

module sajc_axes #(
   parameter int AXES = sajc_pkg::AXES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [sajc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sajc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  sajc_pkg::sajc_axis_ctrl_type          ctrl,
   input  logic [((AXES < sajc_pkg::LIMIT_AXES ? AXES : sajc_pkg::LIMIT_AXES) > 1 ?
                  $clog2(AXES < sajc_pkg::LIMIT_AXES ? AXES : sajc_pkg::LIMIT_AXES) : 1)-1:0]
                                                 rehome_idx,
   output sajc_pkg::sajc_axis_status_type        status
);
   import sajc_pkg::*;

   localparam int NAX  = AXES < LIMIT_AXES ? AXES : LIMIT_AXES;
   localparam int IDXW = NAX > 1 ? $clog2(NAX) : 1;

   logic [LIMIT_AXES-1:0][POS_W-1:0] min_ff;
   logic [LIMIT_AXES-1:0][POS_W-1:0] max_ff;
   logic [NAX-1:0][POS_W-1:0]        pos_ff;
   logic [NAX-1:0]                   sel_ff;

   logic [IDXW-1:0]        tick_idx;
   logic signed [POS_W+1:0] tick_sum;
   logic [POS_W-1:0]       tick_in;
   logic [POS_W-1:0]       rehome_in;

   always_comb begin
      tick_idx  = '0;
      rehome_in = min_ff[0];
      for (int i = NAX - 1; i >= 0; i--) begin
         if (sel_ff[i]) begin
            tick_idx = IDXW'(i);
         end
      end
      for (int i = 0; i < NAX; i++) begin
         if (rehome_idx == IDXW'(i)) begin
            rehome_in = min_ff[i];
         end
      end
      tick_sum = $signed({2'b00, pos_ff[tick_idx]}) + (POS_W+2)'(ctrl.jog_step);
      if (tick_sum < $signed({2'b00, min_ff[tick_idx]})) begin
         tick_in = min_ff[tick_idx];
      end else if (tick_sum > $signed({2'b00, max_ff[tick_idx]})) begin
         tick_in = max_ff[tick_idx];
      end else begin
         tick_in = tick_sum[POS_W-1:0];
      end
      status.tick_hit     = |sel_ff;
      status.tick_index   = 3'(tick_idx);
      status.tick_value   = tick_in;
      status.rehome_value = rehome_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_RESET;
         max_ff <= MAX_RESET;
         sel_ff <= '0;
         for (int i = 0; i < NAX; i++) begin
            pos_ff[i] <= MIN_RESET[i];
         end
      end else begin
         if (csr_we) begin
            if (csr_index[2]) begin
               max_ff[csr_index[1:0]] <= csr_wdata;
            end else begin
               min_ff[csr_index[1:0]] <= csr_wdata;
            end
         end
         if (ctrl.commit) begin
            unique case (ctrl.req_type)
               REQ_BUTTON: begin
                  for (int i = 0; i < NAX; i++) begin
                     if (ctrl.pressed) begin
                        sel_ff[i] <= (ctrl.control_id == 4'(i));
                     end else if (ctrl.control_id == 4'(i)) begin
                        sel_ff[i] <= 1'b0;
                     end
                  end
               end
               REQ_TICK: begin
                  if (|sel_ff) begin
                     pos_ff[tick_idx] <= tick_in;
                  end
               end
               REQ_REHOME: begin
                  sel_ff <= '0;
                  for (int i = 0; i < NAX; i++) begin
                     pos_ff[i] <= min_ff[i];
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

### dv/tb.sv
// Testbench of the servo axis jog controller: event table, then random traffic against a model.
`timescale 1ns / 1ps

module tb;
   import sajc_pkg::*;

   localparam logic [2:0] CSR_AXIS_MIN0 = 3'd0;
   localparam logic [2:0] CSR_AXIS_MAX0 = 3'd4;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 200;

   typedef struct {
      sajc_req_type item;
      int           typed_n;
   } jog_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   sajc_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   sajc_rsp_type rsp_data;
   logic         csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   logic [POS_W-1:0] lim_lo [4];
   logic [POS_W-1:0] lim_hi [4];
   logic [POS_W-1:0] axis_pos [4];
   bit               axis_sel [4];
   bit               motor_on;
   int               jog_step_q;

   sajc_rsp_type step_writes [4];
   int           step_n;
   sajc_rsp_type axis_writes_due [$];
   sajc_rsp_type typed_writes [$];
   jog_row_type  jog_table [$];

   int mismatch_count = 0;
   bit bursts_on = 1'b1;
   bit quiet = 1'b0;
   bit hold_start = 1'b0;
   bit hold_done = 1'b0;

   servo_axis_jog_controller DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic flag_mismatch(input string field, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic put_write(input logic [2:0] idx, input logic [15:0] val);
      step_writes[step_n].reg_index  = idx;
      step_writes[step_n].reg_value  = val;
      step_writes[step_n].last_write = 1'b0;
      step_n++;
   endtask

   task automatic predict_jog(input sajc_req_type t);
      int  sv;
      int  s;
      bit  hit;
      sv = $signed(t.stick_value);
      hit = 1'b0;
      step_n = 0;
      case (t.req_type)
         REQ_BUTTON: begin
            if (t.pressed) begin
               for (int i = 0; i < LIMIT_AXES; i++) axis_sel[i] = (t.control_id == i);
            end else if (t.control_id < LIMIT_AXES) begin
               axis_sel[t.control_id[1:0]] = 1'b0;
            end
            if (t.control_id == MOTOR_BUTTON) motor_on = t.pressed;
         end
         REQ_STICK: begin
            if (t.control_id == STICK_JOG) begin
               jog_step_q = sv / 5000;
               if (motor_on) put_write(MOTOR_REG, 16'(sv / 35));
            end else if (t.control_id == STICK_ANGLE) begin
               s = sv / 100;
               if (s > 300) s = 300;
               if (s < 0) s = 0;
               put_write(ANGLE_REG, 16'(s));
            end
         end
         REQ_TICK: begin
            for (int i = 0; i < LIMIT_AXES; i++) begin
               if (axis_sel[i] && !hit) begin
                  hit = 1'b1;
                  s = int'(axis_pos[i]) + jog_step_q;
                  if (s < int'(lim_lo[i])) s = lim_lo[i];
                  else if (s > int'(lim_hi[i])) s = lim_hi[i];
                  axis_pos[i] = POS_W'(s);
                  put_write(3'(i), 16'(axis_pos[i]));
               end
            end
         end
         default: begin
            for (int i = 0; i < LIMIT_AXES; i++) begin
               axis_pos[i] = lim_lo[i];
               put_write(3'(i), 16'(axis_pos[i]));
               axis_sel[i] = 1'b0;
            end
         end
      endcase
      if (step_n > 0) step_writes[step_n-1].last_write = 1'b1;
   endtask

   task automatic add_row(input sajc_req_kind_type kind, input int id, input bit pr,
                          input int value, input int typed_n);
      jog_row_type r;
      r.item.req_type    = kind;
      r.item.control_id  = 4'(id);
      r.item.pressed     = pr;
      r.item.stick_value = 16'(value);
      r.typed_n          = typed_n;
      jog_table.push_back(r);
   endtask

   task automatic add_write(input logic [2:0] idx, input int val, input bit last);
      sajc_rsp_type w;
      w.reg_index  = idx;
      w.reg_value  = 16'(val);
      w.last_write = last;
      typed_writes.push_back(w);
   endtask

   // Leaves req_valid high on return; the caller either sends again or pauses.
   task automatic send_event(input sajc_req_type t, input int typed_n);
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_jog(t);
      if (typed_n >= 0) begin
         repeat (typed_n) axis_writes_due.push_back(typed_writes.pop_front());
      end else begin
         for (int k = 0; k < step_n; k++) axis_writes_due.push_back(step_writes[k]);
      end
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_gap;
      if (bursts_on && !(hold_start && !hold_done) && $urandom_range(0, 3) == 0)
         pause_sender($urandom_range(1, 19));
   endtask

   task automatic wait_drained;
      pause_sender(1);
      while (axis_writes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_limits(input logic [3:0][POS_W-1:0] mins,
                                 input logic [3:0][POS_W-1:0] maxs);
      for (int i = 0; i < LIMIT_AXES; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_AXIS_MIN0 + 3'(i);
         csr_wdata <= mins[i];
         @(posedge clock);
         lim_lo[i] = mins[i];
      end
      for (int i = 0; i < LIMIT_AXES; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_AXIS_MAX0 + 3'(i);
         csr_wdata <= maxs[i];
         @(posedge clock);
         lim_hi[i] = maxs[i];
      end
      csr_we <= 1'b0;
   endtask

   task automatic make_event(output sajc_req_type t);
      int k;
      logic [3:0] btn [5];
      btn = '{4'd0, 4'd1, 4'd2, 4'd3, MOTOR_BUTTON};
      k = $urandom_range(0, 99);
      t.control_id  = 4'($urandom_range(0, 15));
      t.pressed     = 1'($urandom_range(0, 1));
      t.stick_value = 16'($urandom);
      if (k < 25) begin
         t.req_type = REQ_BUTTON;
         if ($urandom_range(0, 3) != 0) t.control_id = btn[$urandom_range(0, 4)];
         if ($urandom_range(0, 3) != 0) t.pressed = 1'b1;
      end else if (k < 50) begin
         t.req_type = REQ_STICK;
         k = $urandom_range(0, 9);
         if (k < 5) t.control_id = STICK_JOG;
         else if (k < 9) t.control_id = STICK_ANGLE;
         if ($urandom_range(0, 1) == 0) t.stick_value = 16'(int'($urandom_range(0, 24000)) - 12000);
      end else if (k < 92) begin
         t.req_type = REQ_TICK;
      end else begin
         t.req_type = REQ_REHOME;
      end
   endtask

   task automatic run_phase(input int target);
      sajc_req_type t;
      int sent;
      sent = 0;
      while (sent < target) begin
         if (!quiet && sent % 25 == 0) bursts_on = ($urandom_range(0, 2) != 0);
         make_event(t);
         send_event(t, -1);
         sent++;
         maybe_gap();
      end
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_start && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
            rsp_stall <= 1'b0;
         end else if (bursts_on && !quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_writes
      sajc_rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (axis_writes_due.size() == 0) begin
            flag_mismatch("unexpected write to register", rsp_data.reg_index, -1);
         end else begin
            w = axis_writes_due.pop_front();
            if (rsp_data.reg_index !== w.reg_index)
               flag_mismatch("reg_index", rsp_data.reg_index, w.reg_index);
            if (rsp_data.reg_value !== w.reg_value)
               flag_mismatch("reg_value", rsp_data.reg_value, w.reg_value);
            if (rsp_data.last_write !== w.last_write)
               flag_mismatch("last_write", rsp_data.last_write, w.last_write);
         end
      end
   end

   initial begin
      logic [3:0][POS_W-1:0] mins;
      logic [3:0][POS_W-1:0] maxs;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      for (int i = 0; i < LIMIT_AXES; i++) begin
         lim_lo[i]   = MIN_RESET[i];
         lim_hi[i]   = MAX_RESET[i];
         axis_pos[i] = MIN_RESET[i];
         axis_sel[i] = 1'b0;
      end
      motor_on   = 1'b0;
      jog_step_q = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      add_row(REQ_REHOME, 0, 1'b0, 0, 4);
      add_write(3'd0, 150, 1'b0);
      add_write(3'd1, 100, 1'b0);
      add_write(3'd2, 100, 1'b0);
      add_write(3'd3, 100, 1'b1);
      add_row(REQ_STICK, STICK_ANGLE, 1'b0, 32767, 1);
      add_write(ANGLE_REG, 300, 1'b1);
      add_row(REQ_STICK, STICK_ANGLE, 1'b1, -32768, 1);
      add_write(ANGLE_REG, 0, 1'b1);
      add_row(REQ_STICK, STICK_JOG, 1'b0, 32767, 0);
      add_row(REQ_BUTTON, 0, 1'b1, 0, 0);
      add_row(REQ_TICK, 0, 1'b0, 0, -1);
      add_row(REQ_TICK, 15, 1'b1, -1, -1);
      add_row(REQ_BUTTON, MOTOR_BUTTON, 1'b1, 0, 0);
      add_row(REQ_STICK, STICK_JOG, 1'b0, -32768, 1);
      add_write(MOTOR_REG, -936, 1'b1);
      add_row(REQ_TICK, 0, 1'b0, 0, 0);
      add_row(REQ_BUTTON, 2, 1'b1, 0, 0);
      add_row(REQ_TICK, 0, 1'b0, 0, -1);
      add_row(REQ_STICK, STICK_JOG, 1'b0, 32767, 1);
      add_write(MOTOR_REG, 936, 1'b1);
      add_row(REQ_BUTTON, 15, 1'b0, 0, 0);
      add_row(REQ_TICK, 0, 1'b0, 0, -1);
      add_row(REQ_BUTTON, MOTOR_BUTTON, 1'b0, 0, 0);
      add_row(REQ_STICK, STICK_JOG, 1'b0, 4999, 0);
      add_row(REQ_BUTTON, 2, 1'b0, 0, 0);
      add_row(REQ_BUTTON, 3, 1'b1, 0, 0);
      add_row(REQ_STICK, STICK_JOG, 1'b0, 25000, 0);
      add_row(REQ_TICK, 0, 1'b0, 0, -1);
      add_row(REQ_STICK, 0, 1'b1, 16'h5555, 0);
      add_row(REQ_STICK, 15, 1'b0, -1, 0);
      add_row(REQ_STICK, STICK_ANGLE, 1'b0, 12345, 1);
      add_write(ANGLE_REG, 123, 1'b1);
      add_row(REQ_REHOME, 15, 1'b1, -1, 4);
      add_write(3'd0, 150, 1'b0);
      add_write(3'd1, 100, 1'b0);
      add_write(3'd2, 100, 1'b0);
      add_write(3'd3, 100, 1'b1);

      foreach (jog_table[r]) begin
         send_event(jog_table[r].item, jog_table[r].typed_n);
         maybe_gap();
      end
      wait_drained();

      program_limits({4{12'd0}}, {4{12'd4095}});
      run_phase(60);
      wait_drained();

      program_limits({12'd0, 12'd2048, 12'd4095, 12'd4095}, {12'd0, 12'd2048, 12'd0, 12'd0});
      run_phase(60);
      wait_drained();

      for (int i = 0; i < LIMIT_AXES; i++) begin
         mins[i] = POS_W'($urandom_range(0, 4095));
         maxs[i] = POS_W'($urandom_range(0, 4095));
      end
      program_limits(mins, maxs);
      hold_start = 1'b1;
      run_phase(40);
      wait_drained();
      run_phase(40);
      wait_drained();

      quiet     = 1'b1;
      bursts_on = 1'b0;
      program_limits(MIN_RESET, MAX_RESET);
      run_phase(50);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/sajc_pkg.sv
rtl/sajc_stick.sv
rtl/sajc_axes.sv
rtl/servo_axis_jog_controller.sv
dv/tb.sv
